@@ hw/rtl/skvl_pkg.sv @@
`default_nettype none

package skvl_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_GET    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic cmp;    // latch compare flags against the held key
    logic ins;    // open a slot at the insert point and fill it
    logic rep;    // overwrite the value of the matching cell
    logic rem;    // close the gap at the matching cell
    logic qmode;  // insert after equal keys
  } skvl_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/skvl_if.sv @@
`default_nettype none

interface skvl_in_if;
  import skvl_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [KEY_W-1:0]   key;
  logic [VAL_W-1:0]   value_in;

  modport source (output valid, output func, output key, output value_in, input ready);
  modport sink   (input valid, input func, input key, input value_in, output ready);
endinterface

interface skvl_out_if;
  import skvl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    value_out;

  modport source (output valid, output status, output value_out, input ready);
  modport sink   (input valid, input status, input value_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/skvl_cell.sv @@
`default_nettype none

module skvl_cell (
  input  logic                     clk,
  input  skvl_pkg::skvl_ctl_t      ctl,
  input  logic                     occ,
  input  logic [skvl_pkg::KEY_W-1:0] key_q,
  input  logic [skvl_pkg::VAL_W-1:0] val_q,
  input  logic [skvl_pkg::KEY_W-1:0] left_key,
  input  logic [skvl_pkg::VAL_W-1:0] left_val,
  input  logic                     left_lt,
  input  logic                     left_le,
  input  logic [skvl_pkg::KEY_W-1:0] right_key,
  input  logic [skvl_pkg::VAL_W-1:0] right_val,
  output logic [skvl_pkg::KEY_W-1:0] key_r,
  output logic [skvl_pkg::VAL_W-1:0] val_r,
  output logic                     lt_r,
  output logic                     le_r,
  output logic                     hit,
  output logic [skvl_pkg::VAL_W-1:0] hit_val
);
  import skvl_pkg::*;

  logic             eq_r;
  logic             lt_nxt, le_nxt, eq_nxt;
  logic [KEY_W-1:0] key_nxt;
  logic [VAL_W-1:0] val_nxt;
  logic             m, pm;

  // first cell at or past the search key, holding it
  assign hit     = eq_r && left_lt;
  assign hit_val = hit ? val_r : '0;

  always_comb begin
    lt_nxt = lt_r;
    le_nxt = le_r;
    eq_nxt = eq_r;
    if (ctl.cmp) begin
      lt_nxt = occ && (key_r < key_q);
      le_nxt = occ && (key_r <= key_q);
      eq_nxt = occ && (key_r == key_q);
    end
  end

  always_comb begin
    m       = ctl.qmode ? le_r : lt_r;
    pm      = ctl.qmode ? left_le : left_lt;
    key_nxt = key_r;
    val_nxt = val_r;
    if (ctl.rep && hit) begin
      val_nxt = val_q;
    end
    if (ctl.ins && !m) begin
      if (pm) begin
        key_nxt = key_q;
        val_nxt = val_q;
      end else begin
        key_nxt = left_key;
        val_nxt = left_val;
      end
    end
    if (ctl.rem && !lt_r) begin
      key_nxt = right_key;
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    lt_r  <= lt_nxt;
    le_r  <= le_nxt;
    eq_r  <= eq_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_key_value_list.sv @@
`default_nettype none

// Channel  Dir  Payload                      Handshake
// in_if    in   func, key, value_in          valid/ready
// out_if   out  status, value_out            valid/ready
// cfg_*    in   cfg_wdata (queue_mode)       cfg_we, no wait
//
// One operation runs after its beat as a compare cycle in which every
// cell checks its key against the request, then an update cycle in which the
// cells shift or overwrite and the result is registered. One item is in
// flight at a time and ready stays low through both, so a new beat is taken
// only once the update cycle of the last one is done.
// Reset (rst_n low, synchronous) empties the table and sets set mode.
// A stalled output holds the update cycle until the result register frees.

module sorted_key_value_list #(
  parameter int CAPACITY = skvl_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  skvl_in_if.sink           in_if,
  skvl_out_if.source        out_if
);
  import skvl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                mode_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ph1_r, ph2_r, ph2_nxt;
  logic [FUNC_W-1:0]   op_func_r;
  logic [KEY_W-1:0]    op_key_r;
  logic [VAL_W-1:0]    op_val_r;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, status_nxt;
  logic [VAL_W-1:0]    out_value_r, value_nxt;

  logic                in_fire, apply, found, full;
  logic [VAL_W-1:0]    match_val;
  skvl_ctl_t           ctl;

  logic [KEY_W-1:0]    key_a [CAPACITY];
  logic [VAL_W-1:0]    val_a [CAPACITY];
  logic [VAL_W-1:0]    hval_a [CAPACITY];
  logic [CAPACITY-1:0] lt_a, le_a, hit_a;

  assign in_if.ready      = !ph1_r && !ph2_r;
  assign in_fire          = in_if.valid && in_if.ready;
  assign apply            = ph2_r && (!out_valid_r || out_if.ready);
  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_status_r;
  assign out_if.value_out = out_value_r;

  assign found = |hit_a;
  assign full  = (cnt_r == CNT_W'(CAPACITY));

  always_comb begin
    match_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_val = match_val | hval_a[i];
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [KEY_W-1:0] lk, rk;
      logic [VAL_W-1:0] lv, rv;
      logic             llt, lle;

      if (g == 0) begin : g_first
        assign lk  = op_key_r;
        assign lv  = op_val_r;
        assign llt = 1'b1;
        assign lle = 1'b1;
      end else begin : g_mid
        assign lk  = key_a[g-1];
        assign lv  = val_a[g-1];
        assign llt = lt_a[g-1];
        assign lle = le_a[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign rk = key_a[g];
        assign rv = val_a[g];
      end else begin : g_inner
        assign rk = key_a[g+1];
        assign rv = val_a[g+1];
      end

      skvl_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (cnt_r > CNT_W'(g)),
        .key_q     (op_key_r),
        .val_q     (op_val_r),
        .left_key  (lk),
        .left_val  (lv),
        .left_lt   (llt),
        .left_le   (lle),
        .right_key (rk),
        .right_val (rv),
        .key_r     (key_a[g]),
        .val_r     (val_a[g]),
        .lt_r      (lt_a[g]),
        .le_r      (le_a[g]),
        .hit       (hit_a[g]),
        .hit_val   (hval_a[g])
      );
    end
  endgenerate

  always_comb begin
    ctl        = '0;
    ctl.cmp    = ph1_r;
    ctl.qmode  = mode_r;
    status_nxt = ST_OK;
    value_nxt  = '0;
    cnt_nxt    = cnt_r;
    unique case (op_func_r) inside
      FN_INSERT: begin
        if (op_key_r == '0 || op_val_r == '0) begin
          status_nxt = ST_REJECT;
        end else if (!mode_r && found) begin
          ctl.rep = apply;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.ins = apply;
          if (apply) cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      FN_GET, FN_REMOVE: begin
        if (op_key_r == '0 || !found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          value_nxt = match_val;
          if (op_func_r == FN_REMOVE) begin
            ctl.rem = apply;
            if (apply) cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ph2_nxt = ph2_r;
    if (ph1_r) ph2_nxt = 1'b1;
    else if (apply) ph2_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (apply) out_valid_nxt = 1'b1;
    else if (out_if.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      cnt_r       <= '0;
      ph1_r       <= 1'b0;
      ph2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      cnt_r       <= cnt_nxt;
      ph1_r       <= in_fire;
      ph2_r       <= ph2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_func_r <= in_if.func;
      op_key_r  <= in_if.key;
      op_val_r  <= in_if.value_in;
    end
    if (apply) begin
      out_status_r <= status_nxt;
      out_value_r  <= value_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/skvl_checker.sv @@
`default_nettype none

module skvl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [skvl_pkg::STATUS_W-1:0] out_status,
  input logic [skvl_pkg::VAL_W-1:0]    out_value
);
  import skvl_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // a result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // every failed operation reports a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == '0)
    else $error("nonzero value on a failed operation");

  // one operation in flight: no new beat right after one is taken
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input taken while an operation is in flight");

  // a fresh result rises only after a taken request, through the compare and update phases
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_fire, 3))
    else $error("result appeared without a matching request");

endmodule

bind sorted_key_value_list skvl_checker u_skvl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.status),
  .out_value  (out_if.value_out)
);

`default_nettype wire

@@ dv/sorted_key_value_list_test.sv @@
`timescale 1ns / 100ps

module sorted_key_value_list_test;
  import skvl_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int KEY_POOL_N  = 96;
  localparam int QUIET_LIMIT = 1000;
  localparam int SEG_ITEMS   = 140;
  // code 3 has no name in the package: the block treats it as a no-op
  localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } list_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value;
  } list_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  skvl_in_if  in_ch ();
  skvl_out_if out_ch ();

  sorted_key_value_list uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the table
  logic [KEY_W-1:0] tbl_key [CAP];
  logic [VAL_W-1:0] tbl_val [CAP];
  int               tbl_count = 0;
  bit               wait_queue_mode = 1'b0;

  list_op_t    pending_ops [$];
  list_reply_t expected_replies [$];
  logic [KEY_W-1:0] key_pool [KEY_POOL_N];

  int send_idle_pct = 27;
  int recv_idle_pct = 45;
  int mismatches = 0;
  int quiet_cycles = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int peak_fill = 0;

  function automatic list_reply_t apply_op(list_op_t op);
    list_reply_t r;
    int pos;
    int j;
    bit replaced;
    r.status = ST_OK;
    r.value = '0;
    pos = 0;
    replaced = 1'b0;
    case (op.func)
      FN_INSERT: begin
        if (op.key == '0 || op.value == '0) begin
          r.status = ST_REJECT;
        end else begin
          if (!wait_queue_mode) begin
            while (pos < tbl_count && tbl_key[pos] < op.key) pos++;
            if (pos < tbl_count && tbl_key[pos] == op.key) begin
              tbl_val[pos] = op.value;
              replaced = 1'b1;
            end
          end else begin
            // after all equal keys, so duplicates leave in arrival order
            while (pos < tbl_count && tbl_key[pos] <= op.key) pos++;
          end
          if (!replaced) begin
            if (tbl_count >= CAP) begin
              r.status = ST_FULL;
            end else begin
              for (j = tbl_count; j > pos; j--) begin
                tbl_key[j] = tbl_key[j-1];
                tbl_val[j] = tbl_val[j-1];
              end
              tbl_key[pos] = op.key;
              tbl_val[pos] = op.value;
              tbl_count++;
              if (tbl_count > peak_fill) peak_fill = tbl_count;
            end
          end
        end
      end
      FN_GET, FN_REMOVE: begin
        while (pos < tbl_count && tbl_key[pos] < op.key) pos++;
        if (op.key == '0 || pos >= tbl_count || tbl_key[pos] != op.key) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.value = tbl_val[pos];
          if (op.func == FN_REMOVE) begin
            for (j = pos; j + 1 < tbl_count; j++) begin
              tbl_key[j] = tbl_key[j+1];
              tbl_val[j] = tbl_val[j+1];
            end
            tbl_count--;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return {$urandom, $urandom};
    if (r < 45) return key_pool[$urandom_range(15)];  // small set: duplicates, hits
    return key_pool[$urandom_range(KEY_POOL_N - 1)];
  endfunction

  function automatic list_op_t pick_op(int ins_pct, int rem_pct);
    list_op_t op;
    int r;
    int v;
    r = $urandom_range(99);
    v = $urandom_range(99);
    if (r < 2) op.func = FN_NOP;
    else if (r < 2 + ins_pct) op.func = FN_INSERT;
    else if (r < 2 + ins_pct + rem_pct) op.func = FN_REMOVE;
    else op.func = FN_GET;
    op.key = pick_key();
    if (v < 4) op.value = '0;
    else if (v < 7) op.value = '1;
    else op.value = {$urandom, $urandom};
    return op;
  endfunction

  task automatic push_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    pending_ops.push_back('{func: f, key: k, value: v});
  endtask

  task automatic write_mode(bit m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    wait_queue_mode = m;
    @(negedge clk);
  endtask

  task automatic drain();
    wait (pending_ops.size() == 0 && expected_replies.size() == 0);
    @(negedge clk);
  endtask

  // sender: holds a beat until taken, refills from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= '0;
      in_ch.key <= '0;
      in_ch.value_in <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_replies.push_back(apply_op(pending_ops.pop_front()));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.func <= pending_ops[0].func;
          in_ch.key <= pending_ops[0].key;
          in_ch.value_in <= pending_ops[0].value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result beat against the oldest expectation
  always @(posedge clk) begin
    list_reply_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result with nothing outstanding", 64'(out_ch.status), '0);
        end else begin
          want = expected_replies.pop_front();
          status_seen[want.status]++;
          if (out_ch.status !== want.status)
            report_mismatch("status", 64'(out_ch.status), 64'(want.status));
          if (out_ch.value_out !== want.value)
            report_mismatch("value_out", out_ch.value_out, want.value);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("sorted_key_value_list verification failed");
        $finish;
      end
    end
  end

  initial begin
    int seg;
    int n;
    int ins_pct [6];
    int rem_pct [6];
    bit seg_mode [6];

    ins_pct = '{75, 45, 75, 15, 70, 10};
    rem_pct = '{10, 35, 10, 70, 15, 75};
    seg_mode = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

    key_pool[0] = 64'h1;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    key_pool[3] = 64'h7FFF_FFFF_FFFF_FFFF;
    key_pool[4] = 64'h2;
    for (n = 5; n < KEY_POOL_N; n++) key_pool[n] = {$urandom, $urandom};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // set mode: rejects, misses on an empty table, replace, no-op
    write_mode(1'b0);
    push_op(FN_INSERT, '0, 64'h5);
    push_op(FN_INSERT, 64'h7, '0);
    push_op(FN_GET, '0, '1);
    push_op(FN_REMOVE, '0, '1);
    push_op(FN_GET, 64'h7, '0);
    push_op(FN_INSERT, '1, '1);
    push_op(FN_INSERT, 64'h1, 64'h1);
    push_op(FN_INSERT, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
    push_op(FN_GET, '1, '0);
    push_op(FN_INSERT, 64'h1, 64'hAAAA_AAAA_AAAA_AAAA);
    push_op(FN_GET, 64'h1, '0);
    push_op(FN_NOP, '1, '1);
    push_op(FN_REMOVE, 64'h8000_0000_0000_0000, '0);
    push_op(FN_REMOVE, 64'h8000_0000_0000_0000, '0);
    push_op(FN_GET, 64'h2, '0);
    drain();

    // wait-queue mode: equal keys come back oldest first
    write_mode(1'b1);
    push_op(FN_INSERT, 64'h1, 64'h2);
    push_op(FN_INSERT, 64'h1, 64'h3);
    push_op(FN_GET, 64'h1, '0);
    push_op(FN_REMOVE, 64'h1, '0);
    push_op(FN_GET, 64'h1, '0);
    push_op(FN_REMOVE, 64'h1, '0);
    push_op(FN_NOP, '0, '0);
    drain();

    for (seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 45;
        recv_idle_pct = 27;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_mode(seg_mode[seg]);
      for (n = 0; n < SEG_ITEMS; n++) pending_ops.push_back(pick_op(ins_pct[seg], rem_pct[seg]));
      drain();
    end

    repeat (10) @(posedge clk);
    $display("checked %0d results in set and wait-queue modes, peak fill %0d of %0d",
             status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3], peak_fill, CAP);
    $display("status mix: ok %0d, rejected %0d, not found %0d, full %0d",
             status_seen[ST_OK], status_seen[ST_REJECT], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL]);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("sorted_key_value_list verification clean");
    end else begin
      $display("sorted_key_value_list verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/skvl_pkg.sv
hw/rtl/skvl_if.sv
hw/rtl/skvl_cell.sv
hw/rtl/sorted_key_value_list.sv
hw/rtl/skvl_checker.sv
dv/sorted_key_value_list_test.sv
